>>> rtl/cassette_fsk_byte_modulator_top_macros.svh
// Assertion macros shared by the modulator RTL.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef CASSETTE_FSK_BYTE_MODULATOR_TOP_MACROS_SVH
`define CASSETTE_FSK_BYTE_MODULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFSK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfsk_pkg.sv
package cfsk_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int SINE_ENTRIES   = 1024;
    localparam int SINE_IDX_BITS  = $clog2(SINE_ENTRIES);
    localparam int QUARTER        = SINE_ENTRIES / 4;
    localparam int QTR_BITS       = $clog2(QUARTER);
    localparam int MAG_BITS       = 17;

    localparam int CFG_ADDR_BITS = 5;

    localparam logic [2:0] REG_ZERO_LEN  = 3'd0;
    localparam logic [2:0] REG_ONE_LEN   = 3'd1;
    localparam logic [2:0] REG_ZERO_STEP = 3'd2;
    localparam logic [2:0] REG_ONE_STEP  = 3'd3;
    localparam logic [2:0] REG_AMPLITUDE = 3'd4;
    localparam logic [2:0] REG_SQUARE    = 3'd5;
    localparam logic [2:0] REG_LEADER    = 3'd6;
    localparam logic [2:0] REG_TAIL      = 3'd7;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LEADER = 2'd1;
    localparam logic [1:0] OP_BYTE   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_LEADER = 2'd1;
    localparam logic [1:0] MODE_FRAME  = 2'd2;
    localparam logic [1:0] MODE_TAIL   = 2'd3;

    typedef logic [MAG_BITS-1:0] sine_mag_t;
    typedef sine_mag_t sine_rom_t [QUARTER];

    typedef struct packed {
        logic [6:0] amplitude;
        logic       square_mode;
    } wave_cfg_t;

    // Quarter-wave magnitudes in Q16 from the odd polynomial, saturated at unity.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t       rom;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned res;
        for (int k = 0; k < QUARTER; k++)
        begin
            u     = (longint'(k) << 16) / QUARTER;
            u2    = (u * u) >> 16;
            inner = 64'd42047 - ((u2 * 64'd4640) >> 16);
            mid   = 64'd102944 - ((u2 * inner) >> 16);
            res   = (u * mid) >> 16;
            if (res > 64'd65536)
            begin
                res = 64'd65536;
            end
            rom[k] = sine_mag_t'(res);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

>>> rtl/cfsk_wave.sv
module cfsk_wave
    import cfsk_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic [PHASE_BITS-1:0] phase,
    input  wave_cfg_t             cfg,
    output logic [7:0]            wave
);

    logic [SINE_IDX_BITS-1:0] idx;
    logic [QTR_BITS:0]        qtr_idx;
    sine_mag_t                rom_mag;
    logic [23:0]              prod;
    logic [23:0]              rounded;
    logic [6:0]               mag;
    logic                     neg;

    assign idx = phase[PHASE_BITS-1 -: SINE_IDX_BITS];

    // The second and fourth quarters read the table backwards.
    always_comb
    begin
        if (idx[SINE_IDX_BITS-2])
        begin
            qtr_idx = (QTR_BITS+1)'(QUARTER) - {1'b0, idx[QTR_BITS-1:0]};
        end
        else
        begin
            qtr_idx = {1'b0, idx[QTR_BITS-1:0]};
        end
    end

    assign rom_mag = qtr_idx[QTR_BITS] ? sine_mag_t'(65536) : SINE_ROM[qtr_idx[QTR_BITS-1:0]];
    assign prod    = 24'(cfg.amplitude) * 24'(rom_mag);
    assign rounded = prod + 24'd32768;

    always_comb
    begin
        if (cfg.square_mode)
        begin
            mag = cfg.amplitude;
            neg = phase[PHASE_BITS-1];
        end
        else
        begin
            mag = rounded[22:16];
            neg = idx[SINE_IDX_BITS-1];
        end
        wave = neg ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
    end

endmodule

>>> rtl/cassette_fsk_byte_modulator_top.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   opcode, data_byte
// result    out        out_valid / out_ready sample, sample_valid, accepted, ready_res, run_end
// config    in         psel / penable        paddr, pwdata, prdata (APB-style, pready high)
//
// Each request is taken when in_ready is high, and its result enters the output register
// on the edge that takes it, so one request per cycle is sustained while out_ready is high;
// the only path is the sine table look-up and one amplitude multiply ahead of that register.
// A new request is taken while the held result is being read out; a stalled result holds
// the input side only until out_ready returns.
// rst_n clears the run state and loads the register defaults asynchronously.
module cassette_fsk_byte_modulator_top
    import cfsk_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               opcode,
    input  logic [7:0]               data_byte,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [7:0]        sample,
    output logic                     sample_valid,
    output logic                     accepted,
    output logic                     ready_res,
    output logic                     run_end,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

`include "cassette_fsk_byte_modulator_top_macros.svh"

    logic [12:0] zero_len_reg;
    logic [12:0] one_len_reg;
    logic [15:0] zero_step_reg;
    logic [15:0] one_step_reg;
    logic [6:0]  amplitude_reg;
    logic        square_reg;
    logic [19:0] leader_len_reg;
    logic [19:0] tail_len_reg;

    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [9:0]            frame_reg;
    logic [9:0]            frame_next;
    logic [3:0]            bit_pos_reg;
    logic [3:0]            bit_pos_next;
    logic [19:0]           count_reg;
    logic [19:0]           count_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;

    logic       out_valid_reg;
    logic [7:0] sample_reg;
    logic [7:0] sample_next;
    logic       smp_valid_reg;
    logic       smp_valid_next;
    logic       accepted_reg;
    logic       accepted_next;
    logic       ready_res_reg;
    logic       run_end_reg;
    logic       run_end_next;

    logic       in_fire;
    logic       cfg_wr;
    logic [2:0] cfg_idx;
    wave_cfg_t  wave_cfg;
    logic [7:0] wave;
    logic [15:0] frame_ext;
    logic        cur_bit;
    logic [12:0] bit_len;
    logic [12:0] bit_len_eff;
    logic [15:0] bit_step;
    logic [19:0] count_inc;
    logic [3:0]  bit_pos_inc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_len_reg   <= 13'd24;
            one_len_reg    <= 13'd60;
            zero_step_reg  <= 16'd2731;
            one_step_reg   <= 16'd1092;
            amplitude_reg  <= 7'd93;
            square_reg     <= 1'b0;
            leader_len_reg <= 20'd192000;
            tail_len_reg   <= 20'd4800;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ZERO_LEN:  zero_len_reg   <= pwdata[12:0];
                REG_ONE_LEN:   one_len_reg    <= pwdata[12:0];
                REG_ZERO_STEP: zero_step_reg  <= pwdata[15:0];
                REG_ONE_STEP:  one_step_reg   <= pwdata[15:0];
                REG_AMPLITUDE: amplitude_reg  <= pwdata[6:0];
                REG_SQUARE:    square_reg     <= pwdata[0];
                REG_LEADER:    leader_len_reg <= pwdata[19:0];
                REG_TAIL:      tail_len_reg   <= pwdata[19:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ZERO_LEN:  prdata = 32'(zero_len_reg);
            REG_ONE_LEN:   prdata = 32'(one_len_reg);
            REG_ZERO_STEP: prdata = 32'(zero_step_reg);
            REG_ONE_STEP:  prdata = 32'(one_step_reg);
            REG_AMPLITUDE: prdata = 32'(amplitude_reg);
            REG_SQUARE:    prdata = 32'(square_reg);
            REG_LEADER:    prdata = 32'(leader_len_reg);
            REG_TAIL:      prdata = 32'(tail_len_reg);
            default:       prdata = 32'd0;
        endcase
    end

    assign wave_cfg.amplitude   = amplitude_reg;
    assign wave_cfg.square_mode = square_reg;

    cfsk_wave #(
        .PHASE_BITS (PHASE_BITS)
    ) u_wave (
        .phase (phase_reg),
        .cfg   (wave_cfg),
        .wave  (wave)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign frame_ext   = {6'd0, frame_reg};
    assign cur_bit     = frame_ext[bit_pos_reg];
    assign bit_len     = cur_bit ? one_len_reg : zero_len_reg;
    assign bit_len_eff = (bit_len == 13'd0) ? 13'd1 : bit_len;
    assign bit_step    = cur_bit ? one_step_reg : zero_step_reg;
    assign count_inc   = count_reg + 20'd1;
    assign bit_pos_inc = bit_pos_reg + 4'd1;

    always_comb
    begin
        mode_next      = mode_reg;
        frame_next     = frame_reg;
        bit_pos_next   = bit_pos_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        sample_next    = 8'd0;
        smp_valid_next = 1'b0;
        accepted_next  = 1'b0;
        run_end_next   = 1'b0;

        if (opcode != OP_TICK)
        begin
            // Commands are only taken when no run is in progress.
            if (mode_reg == MODE_IDLE)
            begin
                accepted_next = 1'b1;
                phase_next    = '0;
                case (opcode)
                    OP_LEADER:
                    begin
                        count_next = leader_len_reg;
                        if (leader_len_reg != 20'd0)
                        begin
                            mode_next = MODE_LEADER;
                        end
                    end
                    OP_BYTE:
                    begin
                        frame_next   = {^data_byte, data_byte, 1'b1};
                        bit_pos_next = 4'd0;
                        count_next   = 20'd0;
                        mode_next    = MODE_FRAME;
                    end
                    default:
                    begin
                        count_next = tail_len_reg;
                        mode_next  = MODE_TAIL;
                    end
                endcase
            end
        end
        else
        begin
            case (mode_reg)
                MODE_LEADER:
                begin
                    smp_valid_next = 1'b1;
                    sample_next    = wave;
                    phase_next     = phase_reg + PHASE_BITS'(zero_step_reg);
                    count_next     = count_reg - 20'd1;
                    if (count_next == 20'd0)
                    begin
                        run_end_next = 1'b1;
                        mode_next    = MODE_IDLE;
                    end
                end
                MODE_FRAME:
                begin
                    smp_valid_next = 1'b1;
                    sample_next    = wave;
                    phase_next     = phase_reg + PHASE_BITS'(bit_step);
                    count_next     = count_inc;
                    // A bit ends once its sample count reaches the bit length in force; the phase restarts.
                    if (count_inc >= 20'(bit_len_eff))
                    begin
                        count_next   = 20'd0;
                        phase_next   = '0;
                        bit_pos_next = bit_pos_inc;
                        if (bit_pos_inc >= 4'd10)
                        begin
                            bit_pos_next = 4'd0;
                            run_end_next = 1'b1;
                            mode_next    = MODE_IDLE;
                        end
                    end
                end
                MODE_TAIL:
                begin
                    smp_valid_next = 1'b1;
                    if (count_reg == 20'd0)
                    begin
                        run_end_next = 1'b1;
                        mode_next    = MODE_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - 20'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            frame_reg     <= '0;
            bit_pos_reg   <= '0;
            count_reg     <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg    <= mode_next;
                frame_reg   <= frame_next;
                bit_pos_reg <= bit_pos_next;
                count_reg   <= count_next;
                phase_reg   <= phase_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg    <= sample_next;
            smp_valid_reg <= smp_valid_next;
            accepted_reg  <= accepted_next;
            ready_res_reg <= (mode_next == MODE_IDLE);
            run_end_reg   <= run_end_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_valid = smp_valid_reg;
    assign accepted     = accepted_reg;
    assign ready_res    = ready_res_reg;
    assign run_end      = run_end_reg;

    `CFSK_ASSERT_NEXT(a_idle_tick_silent, in_fire && opcode == OP_TICK && mode_reg == MODE_IDLE, !smp_valid_reg && !run_end_reg, "tick while idle produced a sample")
    `CFSK_ASSERT_SAME(a_accept_no_sample, out_valid_reg, !(accepted_reg && smp_valid_reg), "result both accepted a command and carried a sample")
    `CFSK_ASSERT_SAME(a_end_goes_idle, out_valid_reg && run_end_reg, ready_res_reg, "run ended without returning to idle")
    `CFSK_ASSERT_SAME(a_bit_in_frame, mode_reg == MODE_FRAME, bit_pos_reg < 4'd10, "bit position beyond the frame")

endmodule

>>> tb/tb_cassette_fsk_byte_modulator_top.sv
`timescale 1ns / 1ps

module tb_cassette_fsk_byte_modulator_top;
    import cfsk_pkg::*;

    typedef struct packed {
        logic signed [7:0] level;
        logic              valid;
        logic              taken;
        logic              idle;
        logic              last;
    } tape_result_t;

    // Tracks the modulator state and predicts the sample each request produces.
    class tape_sample_board;
        logic [12:0]  zero_len;
        logic [12:0]  one_len;
        logic [15:0]  zero_step;
        logic [15:0]  one_step;
        logic [6:0]   amp;
        logic         square;
        logic [19:0]  leader_len;
        logic [19:0]  tail_len;
        logic [1:0]   mode;
        logic [9:0]   frame;
        logic [3:0]   bit_pos;
        logic [19:0]  count;
        logic [15:0]  phase;
        tape_result_t expected_samples[$];
        int unsigned  mismatches;

        function new();
            zero_len   = 13'd24;
            one_len    = 13'd60;
            zero_step  = 16'd2731;
            one_step   = 16'd1092;
            amp        = 7'd93;
            square     = 1'b0;
            leader_len = 20'd192000;
            tail_len   = 20'd4800;
            mode       = MODE_IDLE;
            frame      = '0;
            bit_pos    = '0;
            count      = '0;
            phase      = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_ZERO_LEN:  zero_len   = value[12:0];
                REG_ONE_LEN:   one_len    = value[12:0];
                REG_ZERO_STEP: zero_step  = value[15:0];
                REG_ONE_STEP:  one_step   = value[15:0];
                REG_AMPLITUDE: amp        = value[6:0];
                REG_SQUARE:    square     = value[0];
                REG_LEADER:    leader_len = value[19:0];
                default:       tail_len   = value[19:0];
            endcase
        endfunction

        function bit busy();
            return mode != MODE_IDLE;
        endfunction

        function int unsigned pending();
            return expected_samples.size();
        endfunction

        // The top two index bits pick the quarter; odd quarters run the table backwards.
        function logic [7:0] tone_level(logic [15:0] ph);
            logic [9:0]      idx;
            logic            neg;
            int unsigned     r;
            longint unsigned u;
            longint unsigned u2;
            longint unsigned inner;
            longint unsigned mid;
            longint unsigned mag;
            if (square)
            begin
                mag = amp;
                neg = ph[15];
            end
            else
            begin
                idx = ph[15:6];
                neg = idx[9];
                r   = 32'(idx[7:0]) * 4;
                if (idx[8])
                begin
                    r = 1024 - r;
                end
                u     = longint'(r) << 6;
                u2    = (u * u) >> 16;
                inner = 42047 - ((u2 * 4640) >> 16);
                mid   = 102944 - ((u2 * inner) >> 16);
                mag   = (u * mid) >> 16;
                if (mag > 65536)
                begin
                    mag = 65536;
                end
                mag = (longint'(amp) * mag + 32768) >> 16;
            end
            return neg ? 8'(256 - mag) : 8'(mag);
        endfunction

        function void predict_sample(logic [1:0] op, logic [7:0] data);
            tape_result_t r;
            logic         level_bit;
            logic [12:0]  len_now;
            logic [15:0]  step_now;
            r = '0;
            if (op != OP_TICK)
            begin
                if (mode == MODE_IDLE)
                begin
                    r.taken = 1'b1;
                    phase   = '0;
                    case (op)
                        OP_LEADER:
                        begin
                            count = leader_len;
                            if (leader_len != 0)
                            begin
                                mode = MODE_LEADER;
                            end
                        end
                        OP_BYTE:
                        begin
                            frame   = {^data, data, 1'b1};
                            bit_pos = '0;
                            count   = '0;
                            mode    = MODE_FRAME;
                        end
                        default:
                        begin
                            count = tail_len;
                            mode  = MODE_TAIL;
                        end
                    endcase
                end
            end
            else
            begin
                case (mode)
                    MODE_LEADER:
                    begin
                        r.valid = 1'b1;
                        r.level = tone_level(phase);
                        phase   = phase + zero_step;
                        count   = count - 1;
                        if (count == 0)
                        begin
                            r.last = 1'b1;
                            mode   = MODE_IDLE;
                        end
                    end
                    MODE_FRAME:
                    begin
                        level_bit = frame[bit_pos];
                        len_now   = level_bit ? one_len : zero_len;
                        step_now  = level_bit ? one_step : zero_step;
                        if (len_now == 0)
                        begin
                            len_now = 13'd1;
                        end
                        r.valid = 1'b1;
                        r.level = tone_level(phase);
                        phase   = phase + step_now;
                        count   = count + 1;
                        // A bit ends against the length in force now, not the one at its start.
                        if (count >= {7'd0, len_now})
                        begin
                            count   = '0;
                            phase   = '0;
                            bit_pos = bit_pos + 1;
                            if (bit_pos >= 4'd10)
                            begin
                                bit_pos = '0;
                                r.last  = 1'b1;
                                mode    = MODE_IDLE;
                            end
                        end
                    end
                    MODE_TAIL:
                    begin
                        r.valid = 1'b1;
                        if (count == 0)
                        begin
                            r.last = 1'b1;
                            mode   = MODE_IDLE;
                        end
                        else
                        begin
                            count = count - 1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            r.idle = (mode == MODE_IDLE);
            expected_samples.push_back(r);
        endfunction

        function void check_result(logic signed [7:0] level, logic valid, logic taken,
                                   logic idle, logic last);
            tape_result_t want;
            if (expected_samples.size() == 0)
            begin
                $error("result with nothing outstanding: sample %0d", level);
                mismatches++;
                return;
            end
            want = expected_samples.pop_front();
            if (level !== want.level)
            begin
                $error("sample: expected %0d, actual %0d", want.level, level);
                mismatches++;
            end
            if (valid !== want.valid)
            begin
                $error("sample_valid: expected %0b, actual %0b", want.valid, valid);
                mismatches++;
            end
            if (taken !== want.taken)
            begin
                $error("accepted: expected %0b, actual %0b", want.taken, taken);
                mismatches++;
            end
            if (idle !== want.idle)
            begin
                $error("ready_res: expected %0b, actual %0b", want.idle, idle);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("run_end: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [1:0]               opcode    = OP_TICK;
    logic [7:0]               data_byte = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [7:0]        sample;
    logic                     sample_valid;
    logic                     accepted;
    logic                     ready_res;
    logic                     run_end;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr     = '0;
    logic [31:0]              pwdata    = '0;
    logic [31:0]              prdata;
    logic                     pready;

    tape_sample_board book;
    bit               burst        = 1'b0;
    bit               hold_request = 1'b0;

    cassette_fsk_byte_modulator_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int unsigned pick_gap();
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // Mostly anything in range, now and then one of the corners.
    function automatic int unsigned corner_or_any(int unsigned hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // All driving tasks start and finish just after a rising edge.
    task automatic set_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_req(logic [1:0] op, logic [7:0] data);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= data;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        book.predict_sample(op, data);
    endtask

    task automatic tick_until_idle();
        while (book.busy())
        begin
            send_req(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic run_cmd(logic [1:0] op, logic [7:0] data);
        send_req(op, data);
        tick_until_idle();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (book.pending() != 0);
    endtask

    task automatic random_setup();
        set_reg(REG_ZERO_LEN, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
                                                         : $urandom_range(2, 30));
        set_reg(REG_ONE_LEN, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
                                                        : $urandom_range(2, 30));
        set_reg(REG_ZERO_STEP, corner_or_any(65535));
        set_reg(REG_ONE_STEP, corner_or_any(65535));
        set_reg(REG_AMPLITUDE, corner_or_any(127));
        set_reg(REG_SQUARE, $urandom_range(0, 1));
        set_reg(REG_LEADER, corner_or_any(50));
        set_reg(REG_TAIL, corner_or_any(40));
    endtask

    // Mostly complete runs with random content; a few requests land while busy and are dropped.
    task automatic random_phase(int unsigned quota);
        int unsigned counted;
        int unsigned loops;
        logic [1:0]  op;
        bit          counts;
        counted = 0;
        loops   = 0;
        while (counted < quota)
        begin
            if (loops % 40 == 0)
            begin
                burst = ($urandom_range(0, 3) == 0);
            end
            loops++;
            if (!book.busy())
            begin
                op     = ($urandom_range(0, 4) == 0) ? OP_TICK : 2'($urandom_range(1, 3));
                counts = (op != OP_TICK);
            end
            else
            begin
                op     = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
                counts = (op == OP_TICK);
            end
            send_req(op, 8'($urandom));
            if (counts)
            begin
                counted++;
            end
        end
        tick_until_idle();
        burst = 1'b0;
    endtask

    initial
    begin : result_side
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
            begin
                @(negedge clk);
            end
            book.check_result(sample, sample_valid, accepted, ready_res, run_end);
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        book  = new();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: idle tick, one frame, and requests dropped while it runs.
        send_req(OP_TICK, 8'hFF);
        send_req(OP_BYTE, 8'hA5);
        repeat (3) send_req(OP_TICK, 8'($urandom));
        send_req(OP_LEADER, 8'h00);
        send_req(OP_END, 8'hFF);
        send_req(OP_BYTE, 8'h3C);
        tick_until_idle();
        drain();

        // Zero-length bits, empty leader and the bare end marker.
        set_reg(REG_ZERO_LEN, 0);
        set_reg(REG_ONE_LEN, 1);
        set_reg(REG_ZERO_STEP, 16'hFFFF);
        set_reg(REG_ONE_STEP, 1);
        set_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        set_reg(REG_SQUARE, 0);
        set_reg(REG_LEADER, 0);
        set_reg(REG_TAIL, 0);
        run_cmd(OP_LEADER, 8'h00);
        send_req(OP_TICK, 8'h00);
        run_cmd(OP_END, 8'h00);
        run_cmd(OP_BYTE, 8'h00);
        run_cmd(OP_BYTE, 8'hFF);
        run_cmd(OP_BYTE, 8'h80);
        run_cmd(OP_BYTE, 8'h01);
        drain();

        set_reg(REG_SQUARE, 1);
        set_reg(REG_ZERO_LEN, 3);
        set_reg(REG_ONE_LEN, 5);
        set_reg(REG_ZERO_STEP, 32768);
        set_reg(REG_ONE_STEP, 16384);
        set_reg(REG_LEADER, 7);
        set_reg(REG_TAIL, 5);
        run_cmd(OP_LEADER, 8'h00);
        run_cmd(OP_BYTE, 8'h5A);
        run_cmd(OP_END, 8'h00);
        drain();

        set_reg(REG_AMPLITUDE, 0);
        set_reg(REG_SQUARE, 0);
        set_reg(REG_ZERO_STEP, 0);
        set_reg(REG_LEADER, 3);
        run_cmd(OP_LEADER, 8'h00);
        run_cmd(OP_BYTE, 8'h3C);
        drain();

        // Bit lengths changed part way through a frame; leader length changed mid-leader.
        set_reg(REG_AMPLITUDE, 77);
        set_reg(REG_ZERO_LEN, 4);
        set_reg(REG_ONE_LEN, 6);
        set_reg(REG_ZERO_STEP, 5000);
        set_reg(REG_ONE_STEP, 9000);
        send_req(OP_BYTE, 8'hF0);
        repeat (8) send_req(OP_TICK, 8'($urandom));
        drain();
        set_reg(REG_ONE_LEN, 2);
        set_reg(REG_ZERO_LEN, 9);
        tick_until_idle();
        drain();
        set_reg(REG_LEADER, 10);
        send_req(OP_LEADER, 8'h00);
        repeat (3) send_req(OP_TICK, 8'($urandom));
        drain();
        set_reg(REG_LEADER, 1);
        tick_until_idle();
        drain();

        // Long bit lengths, run without idling to keep the run short.
        burst = 1'b1;
        set_reg(REG_ONE_LEN, 128);
        set_reg(REG_ZERO_LEN, 2);
        run_cmd(OP_BYTE, 8'h00);
        drain();
        set_reg(REG_ZERO_LEN, 160);
        set_reg(REG_ONE_LEN, 3);
        run_cmd(OP_BYTE, 8'hFF);
        drain();
        burst = 1'b0;
        set_reg(REG_LEADER, 20'hFFFFF);
        set_reg(REG_TAIL, 20'hFFFFF);

        // The receiver holds off for a long stretch while requests keep coming.
        set_reg(REG_LEADER, 60);
        set_reg(REG_TAIL, 12);
        hold_request = 1'b1;
        burst        = 1'b1;
        send_req(OP_LEADER, 8'h00);
        repeat (40) send_req(OP_TICK, 8'($urandom));
        tick_until_idle();
        burst = 1'b0;
        run_cmd(OP_END, 8'h00);
        drain();

        repeat (4)
        begin
            random_setup();
            random_phase(150);
            drain();
        end

        repeat (8) @(posedge clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/cfsk_pkg.sv
rtl/cfsk_wave.sv
rtl/cassette_fsk_byte_modulator_top.sv
tb/tb_cassette_fsk_byte_modulator_top.sv
